// File: hw/rtl/cdc_pkg.sv
package cdc_pkg;

   localparam logic [13:0] YEAR_MAX   = 14'd9999;
   localparam int          DIFF_LIMIT = 65535;
   localparam logic [15:0] DIFF_CAP   = 16'((DIFF_LIMIT > 65535) ? 65535 : DIFF_LIMIT);

   localparam logic [1:0] KIND_LOAD = 2'd0;
   localparam logic [1:0] KIND_ADD  = 2'd1;
   localparam logic [1:0] KIND_DIFF = 2'd2;

   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_FIXED = 2'd1;
   localparam logic [1:0] STAT_LIMIT = 2'd2;
   localparam logic [1:0] STAT_SAT   = 2'd3;

   typedef struct packed {
      logic capture;
      logic fix;
      logic step;
      logic publish;
   } cdc_cmd_type;

   typedef struct packed {
      logic is_run;
      logic run_end;
   } cdc_stat_type;

   function automatic logic leap_year(input logic [13:0] y);
      logic [26:0] prod;
      logic [13:0] q;
      logic [13:0] r;
      logic        div25;
      prod  = 27'(y) * 27'd5243;
      q     = 14'(prod >> 17);
      r     = y - (14'(q << 4) + 14'(q << 3) + q);
      div25 = (r == 14'd0);
      return (y[1:0] == 2'd0) && (!div25 || (y[3:2] == 2'd0));
   endfunction

   function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
      logic [4:0] len;
      unique case (m)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
         4'd2:                                       len = leap ? 5'd29 : 5'd28;
         default:                                    len = 5'd0;
      endcase
      return len;
   endfunction

endpackage

// File: hw/rtl/calendar_date_counter.sv
// channel | direction | handshake           | fields
// req     | in        | req_valid/req_stall | kind, day, month, year, count
// rsp     | out       | rsp_valid/rsp_stall | cur_day, cur_month, cur_year, days_between, status
//
// One item at a time: load and unused kinds pass from capture through the fix and
// done states to the result register; add (count days) and difference (days walked)
// also pass through the run state, one calendar day per cycle through the shared
// next-day step. Synchronous reset sets the date to 1 January of year 1. The result
// register holds under rsp_stall while the next item is already accepted.
module calendar_date_counter
   import cdc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_kind,
   input  logic [5:0]  req_day,
   input  logic [3:0]  req_month,
   input  logic [13:0] req_year,
   input  logic [15:0] req_count,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [4:0]  rsp_cur_day,
   output logic [3:0]  rsp_cur_month,
   output logic [13:0] rsp_cur_year,
   output logic [15:0] rsp_days_between,
   output logic [1:0]  rsp_status
);

   cdc_cmd_type  cmd;
   cdc_stat_type stat;

   cdc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   cdc_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_kind         (req_kind),
      .req_day          (req_day),
      .req_month        (req_month),
      .req_year         (req_year),
      .req_count        (req_count),
      .rsp_cur_day      (rsp_cur_day),
      .rsp_cur_month    (rsp_cur_month),
      .rsp_cur_year     (rsp_cur_year),
      .rsp_days_between (rsp_days_between),
      .rsp_status       (rsp_status)
   );

endmodule

// File: hw/rtl/cdc_ctrl.sv
module cdc_ctrl
   import cdc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   input  cdc_stat_type stat,
   output cdc_cmd_type  cmd
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_FIX  = 2'd1;
   localparam logic [1:0] S_RUN  = 2'd2;
   localparam logic [1:0] S_DONE = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd.capture = (state_ff == S_IDLE) && req_valid;
      cmd.fix     = (state_ff == S_FIX);
      cmd.step    = (state_ff == S_RUN);
      cmd.publish = (state_ff == S_DONE) && out_free;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (req_valid) state_in = S_FIX;
         S_FIX:  state_in = stat.is_run ? S_RUN : S_DONE;
         S_RUN:  if (stat.run_end) state_in = S_DONE;
         S_DONE: if (out_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      if (cmd.publish) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: hw/rtl/cdc_dpath.sv
module cdc_dpath
   import cdc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  cdc_cmd_type  cmd,
   output cdc_stat_type stat,
   input  logic [1:0]   req_kind,
   input  logic [5:0]   req_day,
   input  logic [3:0]   req_month,
   input  logic [13:0]  req_year,
   input  logic [15:0]  req_count,
   output logic [4:0]   rsp_cur_day,
   output logic [3:0]   rsp_cur_month,
   output logic [13:0]  rsp_cur_year,
   output logic [15:0]  rsp_days_between,
   output logic [1:0]   rsp_status
);

   logic [1:0]  kind_ff, kind_in;
   logic [5:0]  iday_ff, iday_in;
   logic [3:0]  imon_ff, imon_in;
   logic [13:0] iyear_ff, iyear_in;
   logic [15:0] cnt_ff, cnt_in;
   logic [1:0]  stat_ff, stat_in;
   logic [4:0]  sd_ff, sd_in;
   logic [3:0]  sm_ff, sm_in;
   logic [13:0] sy_ff, sy_in;
   logic [4:0]  wd_ff, wd_in;
   logic [3:0]  wm_ff, wm_in;
   logic [13:0] wy_ff, wy_in;
   logic [4:0]  od_ff, od_in;
   logic [3:0]  om_ff, om_in;
   logic [13:0] oy_ff, oy_in;
   logic [15:0] ob_ff, ob_in;
   logic [1:0]  os_ff, os_in;

   logic [5:0]  fd;
   logic [3:0]  fm;
   logic [13:0] fy;
   logic [1:0]  fst;
   logic [4:0]  flen;

   logic        is_add;
   logic [4:0]  cd, nd;
   logic [3:0]  cm, nm;
   logic [13:0] cy, ny;
   logic [4:0]  clen;
   logic        step_fail;
   logic        same;

   always_comb begin
      fy  = req_year;
      fst = STAT_OK;
      fy  = iyear_ff;
      fm  = imon_ff;
      fd  = iday_ff;
      if (iyear_ff == 14'd0) begin
         fy  = 14'd1;
         fst = STAT_FIXED;
      end
      if (fy > YEAR_MAX) begin
         fy  = YEAR_MAX;
         fst = STAT_SAT;
      end
      if ((imon_ff == 4'd0) || (imon_ff > 4'd12)) begin
         fm = 4'd1;
         fd = 6'd1;
         if (fst == STAT_OK) fst = STAT_FIXED;
      end
      flen = month_len(fm, leap_year(fy));
      if ((fd == 6'd0) || (fd > {1'b0, flen})) begin
         fd = 6'd1;
         if (fst == STAT_OK) fst = STAT_FIXED;
      end
   end

   assign is_add = (kind_ff == KIND_ADD);

   always_comb begin
      cd = is_add ? sd_ff : wd_ff;
      cm = is_add ? sm_ff : wm_ff;
      cy = is_add ? sy_ff : wy_ff;
      clen      = month_len(cm, leap_year(cy));
      step_fail = 1'b0;
      nd = cd;
      nm = cm;
      ny = cy;
      priority if (cd < clen) begin
         nd = cd + 5'd1;
      end else if (cm < 4'd12) begin
         nd = 5'd1;
         nm = cm + 4'd1;
      end else if (cy >= YEAR_MAX) begin
         step_fail = 1'b1;
      end else begin
         nd = 5'd1;
         nm = 4'd1;
         ny = cy + 14'd1;
      end
   end

   assign same = (wd_ff == sd_ff) && (wm_ff == sm_ff) && (wy_ff == sy_ff);

   always_comb begin
      stat.is_run = (kind_ff == KIND_ADD) || (kind_ff == KIND_DIFF);
      if (is_add) begin
         stat.run_end = (cnt_ff == 16'd0) || step_fail;
      end else begin
         stat.run_end = same || (cnt_ff >= DIFF_CAP) || step_fail;
      end
   end

   always_comb begin
      kind_in  = kind_ff;
      iday_in  = iday_ff;
      imon_in  = imon_ff;
      iyear_in = iyear_ff;
      cnt_in   = cnt_ff;
      stat_in  = stat_ff;
      sd_in    = sd_ff;
      sm_in    = sm_ff;
      sy_in    = sy_ff;
      wd_in    = wd_ff;
      wm_in    = wm_ff;
      wy_in    = wy_ff;
      if (cmd.capture) begin
         kind_in  = req_kind;
         iday_in  = req_day;
         imon_in  = req_month;
         iyear_in = req_year;
         cnt_in   = req_count;
      end
      if (cmd.fix) begin
         stat_in = STAT_OK;
         if (kind_ff == KIND_LOAD) begin
            stat_in = fst;
            sd_in   = fd[4:0];
            sm_in   = fm;
            sy_in   = fy;
         end
         if (kind_ff == KIND_DIFF) begin
            cnt_in = 16'd0;
            wd_in  = fd[4:0];
            wm_in  = fm;
            wy_in  = fy;
         end
      end
      if (cmd.step) begin
         if (is_add) begin
            if (cnt_ff != 16'd0) begin
               if (step_fail) begin
                  stat_in = STAT_SAT;
               end else begin
                  sd_in  = nd;
                  sm_in  = nm;
                  sy_in  = ny;
                  cnt_in = cnt_ff - 16'd1;
               end
            end
         end else if (!same) begin
            if ((cnt_ff >= DIFF_CAP) || step_fail) begin
               stat_in = STAT_LIMIT;
            end else begin
               wd_in  = nd;
               wm_in  = nm;
               wy_in  = ny;
               cnt_in = cnt_ff + 16'd1;
            end
         end
      end
   end

   always_comb begin
      od_in = od_ff;
      om_in = om_ff;
      oy_in = oy_ff;
      ob_in = ob_ff;
      os_in = os_ff;
      if (cmd.publish) begin
         od_in = sd_ff;
         om_in = sm_ff;
         oy_in = sy_ff;
         ob_in = (kind_ff == KIND_DIFF) ? cnt_ff : 16'd0;
         os_in = stat_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sd_ff <= 5'd1;
         sm_ff <= 4'd1;
         sy_ff <= 14'd1;
      end else begin
         sd_ff <= sd_in;
         sm_ff <= sm_in;
         sy_ff <= sy_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff  <= kind_in;
      iday_ff  <= iday_in;
      imon_ff  <= imon_in;
      iyear_ff <= iyear_in;
      cnt_ff   <= cnt_in;
      stat_ff  <= stat_in;
      wd_ff    <= wd_in;
      wm_ff    <= wm_in;
      wy_ff    <= wy_in;
      od_ff    <= od_in;
      om_ff    <= om_in;
      oy_ff    <= oy_in;
      ob_ff    <= ob_in;
      os_ff    <= os_in;
   end

   assign rsp_cur_day      = od_ff;
   assign rsp_cur_month    = om_ff;
   assign rsp_cur_year     = oy_ff;
   assign rsp_days_between = ob_ff;
   assign rsp_status       = os_ff;

endmodule

// File: bench/calendar_date_counter_tb.sv
module calendar_date_counter_tb
   import cdc_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] KIND_NONE = 2'd3;
   localparam int unsigned WATCHDOG_LIMIT = 300000;
   localparam int unsigned RSP_HOLD_CYCLES = 300;

   typedef struct packed {
      logic [4:0]  day;
      logic [3:0]  month;
      logic [13:0] year;
      logic [15:0] between;
      logic [1:0]  status;
   } date_result_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_kind;
   logic [5:0]  req_day;
   logic [3:0]  req_month;
   logic [13:0] req_year;
   logic [15:0] req_count;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [4:0]  rsp_cur_day;
   logic [3:0]  rsp_cur_month;
   logic [13:0] rsp_cur_year;
   logic [15:0] rsp_days_between;
   logic [1:0]  rsp_status;

   date_result_type pending_dates[$];
   int unsigned  cal_day = 1;
   int unsigned  cal_month = 1;
   int unsigned  cal_year = 1;
   int unsigned  errors = 0;
   int unsigned  quiet_cycles = 0;
   int unsigned  kinds_sent[4] = '{default: 0};
   int unsigned  statuses_seen[4] = '{default: 0};
   bit           calm = 1'b0;
   bit           rsp_hold_request = 1'b0;

   calendar_date_counter dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_kind         (req_kind),
      .req_day          (req_day),
      .req_month        (req_month),
      .req_year         (req_year),
      .req_count        (req_count),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_cur_day      (rsp_cur_day),
      .rsp_cur_month    (rsp_cur_month),
      .rsp_cur_year     (rsp_cur_year),
      .rsp_days_between (rsp_days_between),
      .rsp_status       (rsp_status)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic bit is_leap_year(input int unsigned y);
      return (y % 400 == 0) || (y % 4 == 0 && y % 100 != 0);
   endfunction

   function automatic int unsigned days_in_month(input int unsigned m, input int unsigned y);
      unique case (m)
         1, 3, 5, 7, 8, 10, 12: return 31;
         4, 6, 9, 11:           return 30;
         2:                     return is_leap_year(y) ? 29 : 28;
         default:               return 0;
      endcase
   endfunction

   function automatic logic [1:0] correct_date(input int unsigned d, input int unsigned m,
                                               input int unsigned y, output int unsigned od,
                                               output int unsigned om, output int unsigned oy);
      logic [1:0] st;
      st = STAT_OK;
      if (y == 0) begin
         y = 1;
         st = STAT_FIXED;
      end
      if (y > YEAR_MAX) begin
         y = YEAR_MAX;
         st = STAT_SAT;
      end
      if (m < 1 || m > 12) begin
         m = 1;
         d = 1;
         if (st == STAT_OK) st = STAT_FIXED;
      end
      if (d < 1 || d > days_in_month(m, y)) begin
         d = 1;
         if (st == STAT_OK) st = STAT_FIXED;
      end
      od = d;
      om = m;
      oy = y;
      return st;
   endfunction

   // hold at 31 December of the last year
   function automatic bit step_day(inout int unsigned d, inout int unsigned m,
                                   inout int unsigned y);
      if (d < days_in_month(m, y)) begin
         d++;
         return 1'b1;
      end
      if (m < 12) begin
         d = 1;
         m++;
         return 1'b1;
      end
      if (y >= YEAR_MAX) return 1'b0;
      d = 1;
      m = 1;
      y++;
      return 1'b1;
   endfunction

   function automatic date_result_type predict_item(input logic [1:0] kind,
                                                    input int unsigned day,
                                                    input int unsigned month,
                                                    input int unsigned year,
                                                    input int unsigned count);
      date_result_type res;
      int unsigned  d, m, y, n, walked;
      logic [1:0]   st;
      st = STAT_OK;
      walked = 0;
      n = 0;
      unique case (kind)
         KIND_LOAD: st = correct_date(day, month, year, cal_day, cal_month, cal_year);
         KIND_ADD: begin
            while (n < count && st == STAT_OK) begin
               if (step_day(cal_day, cal_month, cal_year)) n++;
               else st = STAT_SAT;
            end
         end
         KIND_DIFF: begin
            void'(correct_date(day, month, year, d, m, y));
            while (!(d == cal_day && m == cal_month && y == cal_year) && st == STAT_OK) begin
               if (walked >= DIFF_CAP || !step_day(d, m, y)) st = STAT_LIMIT;
               else walked++;
            end
         end
         default: ;
      endcase
      res.day = 5'(cal_day);
      res.month = 4'(cal_month);
      res.year = 14'(cal_year);
      res.between = 16'(walked);
      res.status = st;
      kinds_sent[kind]++;
      statuses_seen[st]++;
      return res;
   endfunction

   task automatic send_item(input logic [1:0] kind, input logic [5:0] day,
                            input logic [3:0] month, input logic [13:0] year,
                            input logic [15:0] count);
      while (!calm && $urandom_range(99) < 17) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_day <= day;
      req_month <= month;
      req_year <= year;
      req_count <= count;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_dates.push_back(predict_item(kind, day, month, year, count));
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_dates.size() != 0) @(posedge clock);
   endtask

   task automatic send_random_item();
      int unsigned pick, d, m, y, c;
      logic [1:0]  k;
      pick = $urandom_range(99);
      d = $urandom_range(63);
      m = $urandom_range(15);
      y = $urandom_range(16383);
      c = $urandom_range(65535);
      if (pick < 15) begin
         k = KIND_LOAD;
         y = ($urandom_range(9) == 0) ? $urandom_range(9999, 9990) : $urandom_range(9989, 2);
         m = $urandom_range(12, 1);
         d = $urandom_range(days_in_month(m, y), 1);
      end else if (pick < 22) begin
         k = KIND_LOAD;
      end else if (pick < 55) begin
         k = KIND_ADD;
         c = ($urandom_range(149) == 0) ? $urandom_range(65535) : $urandom_range(400);
      end else if (pick < 95) begin
         // keep the start at or before the held date so the walk stays short
         k = KIND_DIFF;
         if (cal_year < 2 || $urandom_range(9) == 0) begin
            d = cal_day;
            m = cal_month;
            y = cal_year;
         end else if (pick >= 90) begin
            y = cal_year - 1;
         end else if ($urandom_range(1) == 0) begin
            y = cal_year - 1;
            m = $urandom_range(12, 1);
            d = $urandom_range(days_in_month(m, y), 1);
         end else begin
            y = cal_year;
            m = $urandom_range(cal_month, 1);
            d = $urandom_range((m == cal_month) ? cal_day : days_in_month(m, y), 1);
         end
      end else begin
         k = KIND_NONE;
      end
      send_item(k, 6'(d), 4'(m), 14'(y), 16'(c));
   endtask

   task automatic test_load_correction();
      send_item(KIND_LOAD, 15, 6, 2024, 0);
      send_item(KIND_LOAD, 0, 3, 2023, 16'hffff);
      send_item(KIND_LOAD, 63, 7, 2023, 0);
      send_item(KIND_LOAD, 31, 0, 2023, 0);
      send_item(KIND_LOAD, 20, 15, 2023, 0);
      send_item(KIND_LOAD, 29, 2, 1900, 0);
      send_item(KIND_LOAD, 29, 2, 2000, 0);
      send_item(KIND_LOAD, 10, 5, 0, 0);
      send_item(KIND_LOAD, 40, 13, 16383, 0);
      send_item(KIND_NONE, 63, 15, 16383, 16'hffff);
   endtask

   task automatic test_add_rollover();
      send_item(KIND_LOAD, 31, 12, 2023, 0);
      send_item(KIND_ADD, 0, 0, 0, 1);
      send_item(KIND_ADD, 0, 0, 0, 0);
      send_item(KIND_ADD, 0, 0, 0, 16'hffff);
      send_item(KIND_LOAD, 25, 12, 9999, 0);
      send_item(KIND_ADD, 0, 0, 0, 10);
   endtask

   task automatic test_difference_walk();
      send_item(KIND_LOAD, 1, 3, 2024, 0);
      send_item(KIND_DIFF, 1, 3, 2024, 0);
      send_item(KIND_DIFF, 1, 1, 2024, 0);
      send_item(KIND_DIFF, 5, 5, 0, 0);
      send_item(KIND_DIFF, 7, 0, 2023, 0);
      send_item(KIND_LOAD, 31, 12, 9999, 0);
      send_item(KIND_DIFF, 31, 12, 16383, 0);
      send_item(KIND_LOAD, 1, 1, 9990, 0);
      send_item(KIND_DIFF, 1, 1, 9995, 0);
   endtask

   task automatic test_random_traffic(input int unsigned n);
      repeat (n) send_random_item();
   endtask

   task automatic test_no_idle_stretch(input int unsigned n);
      calm = 1'b1;
      test_random_traffic(n);
      calm = 1'b0;
   endtask

   task automatic test_result_hold_off(input int unsigned n);
      rsp_hold_request = 1'b1;
      test_random_traffic(n);
      drain_results();
   endtask

   initial begin : rsp_side
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold_request) begin
            rsp_stall <= 1'b1;
            repeat (RSP_HOLD_CYCLES) @(posedge clock);
            rsp_hold_request = 1'b0;
         end else begin
            rsp_stall <= !calm && ($urandom_range(99) < 17);
         end
      end
   end

   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         errors++;
      end
   endfunction

   always @(posedge clock) begin : check_results
      date_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_dates.size() == 0) begin
            $error("result with no item outstanding");
            errors++;
         end else begin
            want = pending_dates.pop_front();
            check_field("cur_day", want.day, rsp_cur_day);
            check_field("cur_month", want.month, rsp_cur_month);
            check_field("cur_year", want.year, rsp_cur_year);
            check_field("days_between", want.between, rsp_days_between);
            check_field("status", want.status, rsp_status);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : run
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_kind <= KIND_LOAD;
      req_day <= '0;
      req_month <= '0;
      req_year <= '0;
      req_count <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_load_correction();
      test_add_rollover();
      test_difference_walk();
      test_random_traffic(400);
      test_no_idle_stretch(150);
      test_result_hold_off(16);
      test_random_traffic(430);

      drain_results();
      repeat (20) @(posedge clock);
      if (pending_dates.size() != 0) begin
         $error("%0d results never arrived", pending_dates.size());
         errors++;
      end
      $display("Covered %0d loads, %0d adds, %0d differences, %0d unused kinds",
               kinds_sent[KIND_LOAD], kinds_sent[KIND_ADD], kinds_sent[KIND_DIFF],
               kinds_sent[KIND_NONE]);
      $display("Outcomes ok %0d, corrected %0d, limit %0d, saturated %0d; mismatches %0d",
               statuses_seen[STAT_OK], statuses_seen[STAT_FIXED], statuses_seen[STAT_LIMIT],
               statuses_seen[STAT_SAT], errors);
      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
